### rtl/core/bba_pkg.sv
package bba_pkg;

  localparam int unsigned NUM_BITS  = 4096;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MAP_WORDS = NUM_BITS / WORD_W;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned ID_W      = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } sts_code_t;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] block_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] block_id_res;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      rd_scan;
    logic      rd_free;
    logic      wr_alloc;
    logic      wr_free;
    logic      res_cap;
    logic      res_alloc;
    sts_code_t res_code;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_free;
    logic in_range;
    logic chk_valid;
    logic word_has_zero;
    logic last_word;
  } dp_sts_t;

endpackage

### rtl/core/bba_datapath.sv
module bba_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [bba_pkg::ID_W-1:0] cfg_data,
  input  bba_pkg::in_item_t       in_item,
  input  bba_pkg::dp_cmd_t        cmd,
  output bba_pkg::dp_sts_t        sts,
  output bba_pkg::out_item_t      out_item
);

  logic [bba_pkg::WORD_W-1:0]    mem [bba_pkg::MAP_WORDS];
  logic [bba_pkg::MAP_WORDS-1:0] row_valid;

  logic [bba_pkg::ID_W-1:0]   first_block;
  logic                       cmd_q;
  logic [bba_pkg::ID_W-1:0]   idx_q;
  logic [bba_pkg::ADDR_W-1:0] ptr;
  logic                       chk_valid;
  logic [bba_pkg::ADDR_W-1:0] chk_addr;
  logic [bba_pkg::WORD_W-1:0] rd_data;
  logic                       rd_row_ok;
  logic [bba_pkg::ID_W-1:0]   res_id;
  bba_pkg::sts_code_t         res_code;

  logic                       rd_en;
  logic [bba_pkg::ADDR_W-1:0] rd_addr;
  logic [bba_pkg::WORD_W-1:0] word;
  logic [bba_pkg::WORD_W-1:0] inv;
  logic [bba_pkg::WORD_W-1:0] low;
  logic [bba_pkg::BIT_W-1:0]  zero_pos;
  logic [bba_pkg::ID_W-1:0]   alloc_id;
  logic                       wr_en;
  logic [bba_pkg::WORD_W-1:0] wr_data;

  assign rd_en   = cmd.rd_scan | cmd.rd_free;
  assign rd_addr = cmd.rd_free ? bba_pkg::ADDR_W'(idx_q >> bba_pkg::BIT_W) : ptr;

  // rows never written read as all free
  assign word = rd_row_ok ? rd_data : '0;
  assign inv  = ~word;
  assign low  = inv & (~inv + bba_pkg::WORD_W'(1));

  always_comb begin
    zero_pos = '0;
    for (int i = 0; i < int'(bba_pkg::WORD_W); i++) begin
      if (low[i]) begin
        zero_pos = zero_pos | bba_pkg::BIT_W'(i);
      end
    end
  end

  assign alloc_id = first_block + bba_pkg::ID_W'({chk_addr, zero_pos});

  assign wr_en   = cmd.wr_alloc | cmd.wr_free;
  assign wr_data = cmd.wr_alloc ? (word | low)
                 : (word & ~(bba_pkg::WORD_W'(1) << idx_q[bba_pkg::BIT_W-1:0]));

  always_comb begin
    sts.cmd_free      = (cmd_q == bba_pkg::CMD_FREE);
    sts.in_range      = (32'(idx_q) < bba_pkg::NUM_BITS);
    sts.chk_valid     = chk_valid;
    sts.word_has_zero = |inv;
    sts.last_word     = (chk_addr == bba_pkg::ADDR_W'(bba_pkg::MAP_WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_block <= '0;
      row_valid   <= '0;
      chk_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_block <= cfg_data;
      end
      if (wr_en) begin
        row_valid[chk_addr] <= 1'b1;
      end
      chk_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[chk_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_row_ok <= row_valid[rd_addr];
      chk_addr  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= in_item.command;
      idx_q <= in_item.block_id - first_block;
      ptr   <= '0;
    end else if (cmd.rd_scan) begin
      ptr <= ptr + bba_pkg::ADDR_W'(1);
    end
    if (cmd.res_cap) begin
      res_code <= cmd.res_code;
      res_id   <= cmd.res_alloc ? alloc_id : '0;
    end
    if (cmd.out_load) begin
      out_item.block_id_res <= res_id;
      out_item.status       <= res_code;
    end
  end

endmodule

### rtl/core/bba_ctrl.sv
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  input  bba_pkg::dp_sts_t  sts,
  output logic              in_stall,
  output logic              out_valid,
  output bba_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    SCAN,
    FREE_WR,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && (state == IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_code   = bba_pkg::STS_OK;
    state_next     = state;
    unique case (state)
      IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        if (!sts.cmd_free) begin
          cmd.rd_scan = 1'b1;
          state_next  = SCAN;
        end else if (sts.in_range) begin
          cmd.rd_free = 1'b1;
          state_next  = FREE_WR;
        end else begin
          cmd.res_cap  = 1'b1;
          cmd.res_code = bba_pkg::STS_RANGE;
          state_next   = DONE;
        end
      end
      SCAN: begin
        priority if (sts.chk_valid && sts.word_has_zero) begin
          cmd.wr_alloc  = 1'b1;
          cmd.res_cap   = 1'b1;
          cmd.res_alloc = 1'b1;
          state_next    = DONE;
        end else if (sts.chk_valid && sts.last_word) begin
          cmd.res_cap  = 1'b1;
          cmd.res_code = bba_pkg::STS_FULL;
          state_next   = DONE;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      FREE_WR: begin
        cmd.wr_free = 1'b1;
        cmd.res_cap = 1'b1;
        state_next  = DONE;
      end
      DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == DECODE)
    else $error("accepted item did not enter decode");

  a_alloc_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_alloc |-> sts.chk_valid && sts.word_has_zero)
    else $error("allocation write without a free bit");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_free |-> sts.in_range && sts.cmd_free)
    else $error("free write outside managed range");

  a_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register overwritten while held");
`endif

endmodule

### rtl/core/bitmap_block_allocator_top.sv
// allocate scans map words from word 0 until one has a free bit, or reports full after
// the last word; free reads then rewrites its word; an out-of-range id reports STS_RANGE
// throughput: one item at a time, accepted the cycle after the previous result enters
// the output register, so the map scan and output stalls set the rate
// reset: synchronous, clears control state, first_block and the per-word valid bits,
// so every block reads as free at once with no clearing pass
module bitmap_block_allocator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bba_pkg::ID_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bba_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bba_pkg::out_item_t        out_item
);

  bba_pkg::dp_cmd_t cmd;
  bba_pkg::dp_sts_t sts;
  logic             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bba_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

### sim/tb_bitmap_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_top;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 150;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [bba_pkg::ID_W-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  bba_pkg::in_item_t        in_item   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  bba_pkg::out_item_t       out_item;

  bit                       used_map [bba_pkg::NUM_BITS];
  logic [bba_pkg::ID_W-1:0] base_id = '0;
  bba_pkg::in_item_t        request_queue [$];
  bba_pkg::out_item_t       awaited_responses [$];

  int unsigned error_count    = 0;
  int unsigned responses_seen = 0;
  int unsigned send_gap       = 0;
  int unsigned send_burst     = 0;
  int unsigned stall_left     = 0;
  int unsigned calm_left      = 0;
  int unsigned idle_cycles    = 0;

  bitmap_block_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // first-fit allocate or release against the expected map
  function automatic void apply_request(input bba_pkg::in_item_t req);
    bba_pkg::out_item_t       resp;
    logic [bba_pkg::ID_W-1:0] idx;
    int unsigned              b;
    resp = '0;
    resp.status = bba_pkg::STS_OK;
    if (req.command == bba_pkg::CMD_ALLOC) begin
      b = 0;
      while (b < bba_pkg::NUM_BITS && used_map[b]) b++;
      if (b < bba_pkg::NUM_BITS) begin
        used_map[b] = 1'b1;
        idx = b[bba_pkg::ID_W-1:0];
        resp.block_id_res = idx + base_id;
      end else begin
        resp.status = bba_pkg::STS_FULL;
      end
    end else begin
      idx = req.block_id - base_id;
      if (idx >= bba_pkg::NUM_BITS) begin
        resp.status = bba_pkg::STS_RANGE;
      end else begin
        used_map[idx] = 1'b0;
      end
    end
    awaited_responses.push_back(resp);
  endfunction

  function automatic void queue_alloc();
    bba_pkg::in_item_t req;
    req.command  = bba_pkg::CMD_ALLOC;
    req.block_id = bba_pkg::ID_W'($urandom_range(0, 65535));
    request_queue.push_back(req);
  endfunction

  function automatic void queue_free(input logic [bba_pkg::ID_W-1:0] id);
    bba_pkg::in_item_t req;
    req.command  = bba_pkg::CMD_FREE;
    req.block_id = id;
    request_queue.push_back(req);
  endfunction

  // settle at the falling edge so the driver's updates of this step are seen
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (request_queue.size() != 0 || in_valid || awaited_responses.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [bba_pkg::ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_id = value;
  endtask

  task automatic random_phase(input logic [bba_pkg::ID_W-1:0] base,
                              input int unsigned count, input int unsigned free_pct);
    int unsigned              roll;
    logic [bba_pkg::ID_W-1:0] idx;
    wait_drained();
    write_base(base);
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < free_pct) begin
        idx = bba_pkg::ID_W'($urandom_range(0, bba_pkg::NUM_BITS - 1));
        queue_free(idx + base);
      end else if (roll < free_pct + 10) begin
        queue_free(bba_pkg::ID_W'($urandom_range(0, 65535)));
      end else if (roll < free_pct + 14) begin
        case ($urandom_range(0, 3))
          0: queue_free(base - 16'd1);
          1: queue_free(base + bba_pkg::ID_W'(bba_pkg::NUM_BITS));
          2: queue_free(base + bba_pkg::ID_W'(bba_pkg::NUM_BITS - 1));
          default: queue_free(base);
        endcase
      end else begin
        queue_alloc();
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_item);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_item  <= request_queue.pop_front();
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else if ($urandom_range(0, 99) < 3) begin
            send_burst = $urandom_range(20, 60);
            send_gap   = 0;
          end else begin
            send_gap = random_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : receiver
    bba_pkg::out_item_t want;
    int unsigned        roll;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          $error("unexpected item: block_id_res %0d status %0d",
                 out_item.block_id_res, out_item.status);
          error_count++;
        end else begin
          want = awaited_responses.pop_front();
          if (out_item.block_id_res !== want.block_id_res) begin
            $error("block_id_res mismatch: expected %0d, actual %0d",
                   want.block_id_res, out_item.block_id_res);
            error_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_item.status);
            error_count++;
          end
        end
        responses_seen++;
        if (responses_seen == 40 || responses_seen == 700) begin
          stall_left = LONG_HOLD;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          calm_left = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end else if (roll < 25) begin
          stall_left = random_gap();
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first block at its reset value
    queue_alloc();
    queue_alloc();
    queue_alloc();
    queue_free(16'd1);
    queue_alloc();
    queue_free(16'd1);
    queue_free(16'd1);
    queue_free(bba_pkg::ID_W'(bba_pkg::NUM_BITS - 1));
    queue_free(bba_pkg::ID_W'(bba_pkg::NUM_BITS));
    queue_free(16'hFFFF);
    queue_free(16'd0);
    queue_alloc();
    queue_alloc();

    // id wrap with the largest first block
    wait_drained();
    write_base(16'hFFFF);
    queue_alloc();
    queue_free(16'hFFFF);
    queue_free(16'hFFFE);
    queue_free(bba_pkg::ID_W'(bba_pkg::NUM_BITS - 2));
    queue_free(bba_pkg::ID_W'(bba_pkg::NUM_BITS - 1));
    queue_alloc();
    queue_alloc();

    random_phase(16'h0000, 230, 40);
    random_phase(bba_pkg::ID_W'($urandom_range(0, 65535)), 230, 40);
    random_phase(16'h0001, 230, 65);
    random_phase(16'h8000, 230, 30);
    random_phase(bba_pkg::ID_W'($urandom_range(0, 65535)), 230, 45);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bba_pkg.sv
rtl/core/bba_datapath.sv
rtl/core/bba_ctrl.sv
rtl/core/bitmap_block_allocator_top.sv
sim/tb_bitmap_block_allocator_top.sv
